// File: src/bcfp_pkg.sv
// Shared types, character codes and the power-of-ten table for the field parser.
package bcfp_pkg;

    localparam int MANT_W  = 27;
    localparam int FDIG_W  = 3;
    localparam int CHARS_W = 4;
    localparam int SLOT_W  = 3;
    localparam int POW_W   = 24;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int VALUE_W = 32;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_POINT    = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    localparam logic [SLOT_W-1:0] SLOT_THROTTLE = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_PAST     = 3'd4;
    localparam logic [FDIG_W-1:0] FDIG_MAX      = 3'd7;

    // Field parse phase, one-hot
    typedef enum logic [3:0] {
        PH_SIGN = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_STOP = 4'b1000
    } phase_t;

    // One completed field handed from the front end to the converter
    typedef struct packed {
        logic [1:0]        slot;
        logic [MANT_W-1:0] mantissa;
        logic [FDIG_W-1:0] frac_digits;
        logic              negative;
        logic              record_done;
    } field_req_t;

    function automatic logic [POW_W-1:0] pow_ten(input logic [FDIG_W-1:0] n);
        logic [POW_W-1:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

// File: src/bcfp_front.sv
// Character front end: tracks slot and field state and issues one request per completed field.
module bcfp_front #(
    parameter int MAX_CHARS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_code,
    input  logic                record_start,
    input  logic                record_end,
    output logic                req_push,
    output bcfp_pkg::field_req_t req_data
);
    import bcfp_pkg::*;

    logic [SLOT_W-1:0]  slot_reg,  slot_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic [MANT_W-1:0]  mant_reg,  mant_next;
    logic [FDIG_W-1:0]  fdig_reg,  fdig_next;
    logic               neg_reg,   neg_next;
    phase_t             phase_reg, phase_next;

    logic [SLOT_W-1:0]  s_slot;
    logic [CHARS_W-1:0] s_chars, f_chars;
    logic [MANT_W-1:0]  s_mant,  f_mant;
    logic [FDIG_W-1:0]  s_fdig,  f_fdig;
    logic               s_neg,   f_neg;
    phase_t             s_phase, f_phase;
    logic               is_skip, is_comma, is_digit, is_space, do_feed;
    logic               emit_comma, emit_end;
    logic [MANT_W+3:0]  mac;

    always_comb
    begin
        // record start clears slot and field before the character is used
        s_slot  = record_start ? '0 : slot_reg;
        s_chars = record_start ? '0 : chars_reg;
        s_mant  = record_start ? '0 : mant_reg;
        s_fdig  = record_start ? '0 : fdig_reg;
        s_neg   = record_start ? 1'b0 : neg_reg;
        s_phase = record_start ? PH_SIGN : phase_reg;

        is_skip  = char_code inside {CH_LBRACKET, CH_RBRACKET, CH_NUL};
        is_comma = (char_code == CH_COMMA);
        is_digit = char_code inside {[CH_ZERO:CH_NINE]};
        is_space = (char_code == CH_SPACE) || (char_code inside {[CH_TAB:CH_CR]});
        do_feed  = !is_skip && !is_comma && (s_slot < SLOT_PAST)
                   && (s_chars < CHARS_W'(MAX_CHARS));

        mac = {1'b0, s_mant, 3'b000} + {3'b000, s_mant, 1'b0}
              + {{(MANT_W){1'b0}}, char_code[3:0]};

        f_chars = s_chars;
        f_mant  = s_mant;
        f_fdig  = s_fdig;
        f_neg   = s_neg;
        f_phase = s_phase;
        if (do_feed)
        begin
            f_chars = s_chars + 1'b1;
            case (s_phase)
                PH_SIGN:
                begin
                    if (is_space)
                    begin
                        f_phase = PH_SIGN;
                    end
                    else if (char_code == CH_PLUS || char_code == CH_MINUS)
                    begin
                        f_neg   = (char_code == CH_MINUS);
                        f_phase = PH_INT;
                    end
                    else if (is_digit)
                    begin
                        f_mant  = mac[MANT_W-1:0];
                        f_phase = PH_INT;
                    end
                    else if (char_code == CH_POINT)
                    begin
                        f_phase = PH_FRAC;
                    end
                    else
                    begin
                        f_phase = PH_STOP;
                    end
                end
                PH_INT:
                begin
                    if (is_digit)
                        f_mant = mac[MANT_W-1:0];
                    else if (char_code == CH_POINT)
                        f_phase = PH_FRAC;
                    else
                        f_phase = PH_STOP;
                end
                PH_FRAC:
                begin
                    if (is_digit && s_fdig < FDIG_MAX)
                    begin
                        f_mant = mac[MANT_W-1:0];
                        f_fdig = s_fdig + 1'b1;
                    end
                    else
                    begin
                        f_phase = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    f_phase = PH_STOP;
                end
                default:
                begin
                    f_phase = PH_STOP;
                end
            endcase
        end

        emit_comma = is_comma && (s_slot < SLOT_THROTTLE);
        emit_end   = !is_comma && record_end && (f_slot_is_throttle(s_slot))
                     && (f_chars != '0);

        req_push             = accept && (emit_comma || emit_end);
        req_data.slot        = s_slot[1:0];
        req_data.mantissa    = f_mant;
        req_data.frac_digits = f_fdig;
        req_data.negative    = f_neg;
        req_data.record_done = record_end;

        if (is_comma)
        begin
            slot_next  = (s_slot < SLOT_PAST) ? s_slot + 1'b1 : s_slot;
            chars_next = '0;
            mant_next  = '0;
            fdig_next  = '0;
            neg_next   = 1'b0;
            phase_next = PH_SIGN;
        end
        else
        begin
            slot_next  = s_slot;
            chars_next = f_chars;
            mant_next  = f_mant;
            fdig_next  = f_fdig;
            neg_next   = f_neg;
            phase_next = f_phase;
        end
    end

    function automatic logic f_slot_is_throttle(input logic [SLOT_W-1:0] s);
        return s == SLOT_THROTTLE;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            chars_reg <= '0;
            mant_reg  <= '0;
            fdig_reg  <= '0;
            neg_reg   <= 1'b0;
            phase_reg <= PH_SIGN;
        end
        else if (accept)
        begin
            slot_reg  <= slot_next;
            chars_reg <= chars_next;
            mant_reg  <= mant_next;
            fdig_reg  <= fdig_next;
            neg_reg   <= neg_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// File: src/bcfp_queue.sv
// Short request queue between the character front end and the converter.
module bcfp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bcfp_pkg::field_req_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output bcfp_pkg::field_req_t head
);
    import bcfp_pkg::*;

    field_req_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/bcfp_back.sv
// Converter: bit-serial divide by a power of ten, saturate, and hold the result for the receiver.
module bcfp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  bcfp_pkg::field_req_t req_data,
    output logic                 req_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           slot,
    output logic signed [31:0]   value,
    output logic                 record_done
);
    import bcfp_pkg::*;

    localparam int DW    = MANT_W + FRAC_BITS;
    localparam int RW    = POW_W + 1;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DW-1:0]      quo_reg,   quo_next;
    logic [RW-1:0]      rem_reg,   rem_next;
    logic [POW_W-1:0]   div_reg,   div_next;
    logic [1:0]         slot_reg,  slot_next;
    logic               neg_reg,   neg_next;
    logic               done_reg,  done_next;
    logic               ovalid_reg, ovalid_next;
    logic [1:0]         oslot_reg;
    logic [VALUE_W-1:0] ovalue_reg;
    logic               odone_reg;

    logic [RW-1:0]      rem_sh;
    logic               ge;
    logic               mag_hi;
    logic [VALUE_W-1:0] sat_value;
    logic               load_out;

    always_comb
    begin
        rem_sh = {rem_reg[RW-2:0], quo_reg[DW-1]};
        ge     = (rem_sh >= {1'b0, div_reg});
        mag_hi = |quo_reg[DW-1:VALUE_W-1];

        // saturate to the signed 32-bit range, then apply the sign
        if (neg_reg)
        begin
            if (mag_hi)
                sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
            else
                sat_value = VALUE_W'(0) - quo_reg[VALUE_W-1:0];
        end
        else
        begin
            if (mag_hi)
                sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
            else
                sat_value = quo_reg[VALUE_W-1:0];
        end

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        slot_next   = slot_reg;
        neg_next    = neg_reg;
        done_next   = done_reg;
        req_pop     = 1'b0;
        load_out    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop    = 1'b1;
                    quo_next   = {req_data.mantissa, {(FRAC_BITS){1'b0}}};
                    rem_next   = '0;
                    div_next   = pow_ten(req_data.frac_digits);
                    slot_next  = req_data.slot;
                    neg_next   = req_data.negative;
                    done_next  = req_data.record_done;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? rem_sh - {1'b0, div_reg} : rem_sh;
                quo_next = {quo_reg[DW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DW - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!ovalid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
            ovalid_next = 1'b1;
        else if (result_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        slot_reg <= slot_next;
        neg_reg  <= neg_next;
        done_reg <= done_next;
        if (load_out)
        begin
            oslot_reg  <= slot_reg;
            ovalue_reg <= sat_value;
            odone_reg  <= done_reg;
        end
    end

    assign result_valid = ovalid_reg;
    assign slot         = oslot_reg;
    assign value        = ovalue_reg;
    assign record_done  = odone_reg;

endmodule

// File: src/bracket_csv_four_float_parser_core.sv
// Top level of the bracketed comma-separated four-field decimal parser.
//
// Usage:
//   Characters enter on the char channel (char_code, record_start, record_end
//   with char_valid / char_ready). Mark the first character of each record with
//   record_start and the last with record_end. Results leave on the result
//   channel (slot, value, record_done with result_valid / result_ready); value
//   is signed fixed point with FRAC_BITS fraction bits, rounded toward zero and
//   saturated. A comma closes slots 0 to 2; slot 3 closes on the record's last
//   character when it holds any characters.
// Flow:
//   The front end takes one character per cycle as long as the four-entry
//   request queue has room. Each completed field is converted by a shared
//   bit-serial divider (one quotient bit per cycle), which takes the next field
//   from the queue only after it has loaded the current result into the output
//   register. A burst of closely spaced fields fills the queue, and char_ready
//   drops while it is full.
// Reset:
//   rst_n clears slot and field state, empties the queue and drops
//   result_valid. When the receiver stalls, the result register holds its
//   request; the converter finishes the next field and waits behind it.
module bracket_csv_four_float_parser_core #(
    parameter int MAX_CHARS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  logic [7:0]         char_code,
    input  logic               record_start,
    input  logic               record_end,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         slot,
    output logic signed [31:0] value,
    output logic               record_done
);
    import bcfp_pkg::*;

    logic       accept;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    field_req_t q_in;
    field_req_t q_head;

    // accept a character whenever the queue can take a possible request
    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;

    bcfp_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (char_code),
        .record_start (record_start),
        .record_end   (record_end),
        .req_push     (q_push),
        .req_data     (q_in)
    );

    bcfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bcfp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (q_not_empty),
        .req_data     (q_head),
        .req_pop      (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .slot         (slot),
        .value        (value),
        .record_done  (record_done)
    );

endmodule

// File: src/bcfp_checker.sv
// Port-level checks for the parser core, attached by bind.
module bcfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  slot,
    input logic [31:0] value,
    input logic        record_done
);

    // a stalled result request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(slot) && $stable(value) && $stable(record_done))
        else $error("result request changed while stalled");

    // throttle is only ever produced by the record's last character
    a_throttle_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (slot == 2'd3) |-> record_done)
        else $error("throttle result without record_done");

    // the converter cannot deliver three results on consecutive edges
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready) ##1 (result_valid && result_ready) |=> !result_valid)
        else $error("results closer than the converter allows");

    // no result right after reset is released
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result present right after reset");

endmodule

bind bracket_csv_four_float_parser_core bcfp_checker u_checker (.*);
